// File: design/crt_pkg.sv
// shared constants and control types for the catmull-rom curve tessellator
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

    localparam int COORD_BITS  = 16;
    localparam int MAX_SAMPLES = 64;
    localparam int CFG_W       = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(20);

    // t is unsigned q0.16
    localparam int T_W = 16;
    // reciprocal 2^16 / n needs one more bit for n = 1
    localparam int Q_W       = T_W + 1;
    localparam int DIV_STEPS = Q_W;
    localparam int CNT_W     = ($clog2(MAX_SAMPLES) > $clog2(DIV_STEPS)) ?
                               $clog2(MAX_SAMPLES) : $clog2(DIV_STEPS);

    // coefficient widths: a = p2-p0, b = 2p0-5p1+4p2-p3, c = -p0+3p1-3p2+p3
    localparam int A_W   = COORD_BITS + 1;
    localparam int B_W   = COORD_BITS + 4;
    localparam int C_W   = COORD_BITS + 3;
    localparam int SUM_W = COORD_BITS + T_W + 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic latch_p3;
        logic shift_in;
        logic clear;
        logic div_start;
        logic div_step;
        logic load;
        logic issue;
        logic last;
    } crt_cmd_t;

    typedef struct packed {
        logic pipe_empty;
        logic pipe_en;
    } crt_sts_t;

endpackage

`default_nettype wire

// File: design/crt_dp.sv
// datapath: point window, reciprocal divider, t stepper and sample pipeline
`timescale 1ns / 1ps
`default_nettype none

module crt_dp
    import crt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire crt_cmd_t         cmd,
    input  wire logic [CFG_W-1:0] n_eff,
    input  wire coord_t           anchor_x,
    input  wire coord_t           anchor_y,
    input  wire logic             out_stall,
    output crt_sts_t              sts,
    output coord_t                point_x,
    output coord_t                point_y,
    output logic                  segment_end,
    output logic                  out_valid
);

    localparam int AT_W = A_W + T_W + 1;
    localparam int BT_W = B_W + T_W + 1;
    localparam int CT_W = C_W + T_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (COORD_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(2 ** (COORD_BITS - 1));
    localparam logic signed [SUM_W-1:0] RND    = SUM_W'(2 ** T_W);

    coord_t anchor_in [2];
    coord_t win_reg [3][2];
    coord_t p3_reg [2];

    // reciprocal divider state
    logic [CFG_W-1:0] rem_reg;
    logic [Q_W-1:0]   dvd_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [CFG_W:0]   rem_sh;
    logic             q_bit;

    // t stepper
    logic [Q_W-1:0]   tacc_reg;
    logic [CFG_W-1:0] racc_reg;
    logic [CFG_W:0]   racc_sum;
    logic             racc_wrap;

    // per-segment coefficients
    logic signed [A_W-1:0] a_reg [2];
    logic signed [B_W-1:0] b_reg [2];
    logic signed [C_W-1:0] c_reg [2];
    coord_t                p1_reg [2];

    // pipeline
    logic             v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic             last1_reg, last2_reg, last3_reg, last4_reg, seg_end_reg;
    logic [T_W-1:0]   t1_reg, t1d_reg, t2_reg, t3_reg;
    logic [2*T_W-1:0] sq_t, cube_t;
    logic signed [AT_W-1:0]  at_reg [2];
    logic signed [BT_W-1:0]  bt_reg [2];
    logic signed [CT_W-1:0]  ct_reg [2];
    logic signed [SUM_W-1:0] pa_reg [2];
    logic signed [SUM_W-1:0] sum_c [2];
    logic signed [SUM_W-1:0] shr_c [2];
    coord_t                  res_c [2];
    coord_t                  res_reg [2];
    logic                    en;

    assign anchor_in[0] = anchor_x;
    assign anchor_in[1] = anchor_y;

    assign en             = !(out_valid_reg && out_stall);
    assign sts.pipe_en    = en;
    assign sts.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);

    assign rem_sh    = {rem_reg, dvd_reg[Q_W-1]};
    assign q_bit     = (rem_sh >= {1'b0, n_eff});
    assign racc_sum  = {1'b0, racc_reg} + {1'b0, rem_reg};
    assign racc_wrap = (racc_sum >= {1'b0, n_eff});

    assign sq_t   = t1_reg * t1_reg;
    assign cube_t = t2_reg * t1d_reg;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            sum_c[k] = pa_reg[k] + SUM_W'(ct_reg[k]);
            shr_c[k] = (sum_c[k] + RND) >>> (T_W + 1);
            if (shr_c[k] > SAT_HI)
            begin
                res_c[k] = SAT_HI[COORD_BITS-1:0];
            end
            else if (shr_c[k] < SAT_LO)
            begin
                res_c[k] = SAT_LO[COORD_BITS-1:0];
            end
            else
            begin
                res_c[k] = shr_c[k][COORD_BITS-1:0];
            end
        end
    end

    // control state of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_p3)
        begin
            for (int k = 0; k < 2; k++)
            begin
                p3_reg[k] <= anchor_in[k];
            end
        end

        if (cmd.shift_in)
        begin
            for (int k = 0; k < 2; k++)
            begin
                win_reg[0][k] <= cmd.clear ? '0 : win_reg[1][k];
                win_reg[1][k] <= cmd.clear ? '0 : win_reg[2][k];
                win_reg[2][k] <= anchor_in[k];
            end
        end
        else if (cmd.load)
        begin
            for (int k = 0; k < 2; k++)
            begin
                win_reg[0][k] <= win_reg[1][k];
                win_reg[1][k] <= win_reg[2][k];
                win_reg[2][k] <= p3_reg[k];
            end
        end

        // restoring divide of 2^16 by n, one quotient bit per cycle
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            dvd_reg <= Q_W'(1) << T_W;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? CFG_W'(rem_sh - {1'b0, n_eff}) : rem_sh[CFG_W-1:0];
            dvd_reg <= dvd_reg << 1;
            quo_reg <= {quo_reg[Q_W-2:0], q_bit};
        end

        if (cmd.load)
        begin
            tacc_reg <= '0;
            racc_reg <= n_eff >> 1;
            for (int k = 0; k < 2; k++)
            begin
                a_reg[k]  <= A_W'(win_reg[2][k]) - A_W'(win_reg[0][k]);
                b_reg[k]  <= (B_W'(win_reg[0][k]) <<< 1) - (B_W'(win_reg[1][k]) <<< 2)
                             - B_W'(win_reg[1][k]) + (B_W'(win_reg[2][k]) <<< 2)
                             - B_W'(p3_reg[k]);
                c_reg[k]  <= (C_W'(win_reg[1][k]) <<< 1) + C_W'(win_reg[1][k])
                             - (C_W'(win_reg[2][k]) <<< 1) - C_W'(win_reg[2][k])
                             + C_W'(p3_reg[k]) - C_W'(win_reg[0][k]);
                p1_reg[k] <= win_reg[1][k];
            end
        end
        else if (cmd.issue)
        begin
            // t steps by q = 2^16 / n, carrying the remainder
            tacc_reg <= tacc_reg + quo_reg + Q_W'(racc_wrap);
            racc_reg <= racc_wrap ? CFG_W'(racc_sum - {1'b0, n_eff})
                                  : racc_sum[CFG_W-1:0];
        end

        if (en)
        begin
            t1_reg    <= tacc_reg[T_W-1:0];
            last1_reg <= cmd.last;

            t2_reg    <= T_W'((sq_t + (2*T_W)'(2 ** (T_W - 1))) >> T_W);
            t1d_reg   <= t1_reg;
            last2_reg <= last1_reg;

            t3_reg    <= T_W'((cube_t + (2*T_W)'(2 ** (T_W - 1))) >> T_W);
            last3_reg <= last2_reg;
            last4_reg <= last3_reg;
            seg_end_reg <= last4_reg;

            for (int k = 0; k < 2; k++)
            begin
                at_reg[k]  <= a_reg[k] * $signed({1'b0, t1d_reg});
                bt_reg[k]  <= b_reg[k] * $signed({1'b0, t2_reg});
                ct_reg[k]  <= c_reg[k] * $signed({1'b0, t3_reg});
                pa_reg[k]  <= (SUM_W'(p1_reg[k]) <<< (T_W + 1)) + SUM_W'(at_reg[k])
                              + SUM_W'(bt_reg[k]);
                res_reg[k] <= res_c[k];
            end
        end
    end

    assign point_x     = res_reg[0];
    assign point_y     = res_reg[1];
    assign segment_end = seg_end_reg;
    assign out_valid   = out_valid_reg;

endmodule

`default_nettype wire

// File: design/crt_ctrl.sv
// controller: config register, window fill, divider and sample sequencing
`timescale 1ns / 1ps
`default_nettype none

module crt_ctrl
    import crt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    input  wire logic [CFG_W-1:0] cfg_data,
    output logic                  cfg_ready,
    input  wire logic             in_valid,
    input  wire logic             start_loop,
    output logic                  in_stall,
    input  wire crt_sts_t         sts,
    output crt_cmd_t              cmd,
    output logic [CFG_W-1:0]      n_eff
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DRAIN,
        ST_ISSUE
    } state_t;

    state_t           state_reg;
    logic [CFG_W-1:0] cfg_reg;
    logic [1:0]       fill_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]       fill_eff;
    logic             accept;
    logic             full;
    logic             last_sample;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign fill_eff  = start_loop ? 2'd0 : fill_reg;
    assign full      = (fill_eff == 2'd3);

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_eff = CFG_W'(1);
        end
        else if (cfg_reg > CFG_W'(MAX_SAMPLES))
        begin
            n_eff = CFG_W'(MAX_SAMPLES);
        end
        else
        begin
            n_eff = cfg_reg;
        end
    end

    assign last_sample = (cnt_reg == CNT_W'(n_eff - CFG_W'(1)));

    always_comb
    begin
        cmd.latch_p3  = accept;
        cmd.shift_in  = accept && !full;
        cmd.clear     = start_loop;
        cmd.div_start = accept && full;
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.load      = (state_reg == ST_DRAIN) && sts.pipe_empty;
        cmd.issue     = (state_reg == ST_ISSUE) && sts.pipe_en;
        cmd.last      = cmd.issue && last_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cfg_reg   <= CFG_RESET;
            fill_reg  <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (full)
                        begin
                            state_reg <= ST_DIV;
                            cnt_reg   <= '0;
                        end
                        else
                        begin
                            fill_reg <= fill_eff + 2'd1;
                        end
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (sts.pipe_empty)
                    begin
                        state_reg <= ST_ISSUE;
                        cnt_reg   <= '0;
                    end
                end
                ST_ISSUE:
                begin
                    if (sts.pipe_en)
                    begin
                        if (last_sample)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: design/catmull_rom_curve_tessellator.sv
// top level of the uniform catmull-rom curve tessellator
// control points (signed q12.4) arrive on the input channel (in_valid / in_stall);
// a transaction is taken when in_valid is high and in_stall is low.
// the block keeps the three previous points; once three are held, each new
// point completes a segment and the block emits n samples, the configured count,
// on the output channel (out_valid / out_stall), segment_end on the last one.
// n is written through cfg_valid / cfg_ready / cfg_data (reset 20, 0 acts as 1,
// values above 64 act as 64); write it only while the block is idle.
// a point that does not complete a segment leaves the input free.
// a point that completes a segment holds the input through one accept, the
// bit-serial 2^16 / n reciprocal divider (17 quotient bits), a wait for the
// pipeline to empty, one coefficient load, then one sample per cycle, unless the
// output stalls, into a five stage pipeline whose registers lead to the output.
// a stalled receiver freezes the whole sample pipeline; the next point is still
// accepted while the last samples drain.
// reset clears the window fill, the state machine and the pipeline valids,
// and restores n to 20.
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_curve_tessellator
    import crt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // configuration write
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    // control point input
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire coord_t           anchor_x,
    input  wire coord_t           anchor_y,
    input  wire logic             start_loop,
    // curve sample output
    output logic                  out_valid,
    input  wire logic             out_stall,
    output coord_t                point_x,
    output coord_t                point_y,
    output logic                  segment_end
);

    crt_cmd_t         cmd;
    crt_sts_t         sts;
    logic [CFG_W-1:0] n_eff;

    // sequencing: fill tracking, divider steps, load and issue
    crt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .cfg_ready  (cfg_ready),
        .in_valid   (in_valid),
        .start_loop (start_loop),
        .in_stall   (in_stall),
        .sts        (sts),
        .cmd        (cmd),
        .n_eff      (n_eff)
    );

    // arithmetic: window, reciprocal, t powers, polynomial, round and saturate
    crt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .n_eff       (n_eff),
        .anchor_x    (anchor_x),
        .anchor_y    (anchor_y),
        .out_stall   (out_stall),
        .sts         (sts),
        .point_x     (point_x),
        .point_y     (point_y),
        .segment_end (segment_end),
        .out_valid   (out_valid)
    );

    // coefficients only change when no sample is in flight
    a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> sts.pipe_empty)
        else $error("coefficient load with samples in flight");

    // a sample is only pushed when the pipeline moves
    a_issue_en: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> sts.pipe_en)
        else $error("sample issued into a frozen pipeline");

    // the controller drives at most one datapath operation per cycle
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.shift_in, cmd.div_start, cmd.div_step, cmd.load, cmd.issue}))
        else $error("overlapping datapath commands");

    // a segment closes the issue phase and frees the input next cycle
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.last |=> !in_stall)
        else $error("input still stalled after last sample issued");

endmodule

`default_nettype wire

// File: bench/tb.sv
// self-checking testbench for the catmull-rom curve tessellator
`timescale 1ns / 1ps

module tb
    import crt_pkg::*;
();

    typedef struct {
        coord_t x;
        coord_t y;
        logic   start;
    } anchor_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
    } sample_t;

    logic             clk;
    logic             rst_n      = 1'b0;
    logic             cfg_valid  = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data   = '0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    coord_t           anchor_x   = '0;
    coord_t           anchor_y   = '0;
    logic             start_loop = 1'b0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    coord_t           point_x;
    coord_t           point_y;
    logic             segment_end;

    catmull_rom_curve_tessellator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .anchor_x    (anchor_x),
        .anchor_y    (anchor_y),
        .start_loop  (start_loop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .segment_end (segment_end)
    );

    // control points waiting to be driven, curve samples still owed by the block
    anchor_t anchor_feed[$];
    sample_t due_samples[$];
    int      sample_errors = 0;
    // chance in percent that either side starts an idle burst
    int      idle_pct      = 0;

    // shadow of the block: point window, fill level and samples per segment
    coord_t           win_x[3];
    coord_t           win_y[3];
    int               win_fill;
    logic [CFG_W-1:0] seg_samples;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // one axis of a segment sample, q12.4 in and out, rounded half up and saturated
    function automatic coord_t blend_axis(longint p0, longint p1, longint p2, longint p3,
                                          longint t, longint t2, longint t3);
        longint a;
        longint b;
        longint c;
        longint acc;
        longint hi;
        longint lo;
        a   = p2 - p0;
        b   = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c   = -p0 + 3 * p1 - 3 * p2 + p3;
        acc = 2 * p1 * 65536 + a * t + b * t2 + c * t3;
        acc = (acc + 65536) >>> 17;
        hi  = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        lo  = -(longint'(1) <<< (COORD_BITS - 1));
        if (acc > hi)
            acc = hi;
        if (acc < lo)
            acc = lo;
        return coord_t'(acc);
    endfunction

    // take one control point: emit the samples of the segment it completes, then shift it in
    function automatic void tessellate_anchor(coord_t x, coord_t y, logic start);
        longint  n;
        longint  t;
        longint  t2;
        longint  t3;
        sample_t smp;
        if (start)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_x[i] = '0;
                win_y[i] = '0;
            end
            win_fill = 0;
        end
        if (win_fill >= 3)
        begin
            n = seg_samples;
            if (n == 0)
                n = 1;
            if (n > MAX_SAMPLES)
                n = MAX_SAMPLES;
            for (longint s = 0; s < n; s++)
            begin
                t  = (s * 65536 + n / 2) / n;
                t2 = (t * t + 32768) >> 16;
                t3 = (t2 * t + 32768) >> 16;
                smp.x    = blend_axis(win_x[0], win_x[1], win_x[2], x, t, t2, t3);
                smp.y    = blend_axis(win_y[0], win_y[1], win_y[2], y, t, t2, t3);
                smp.last = (s + 1 == n);
                due_samples.insert(due_samples.size(), smp);
            end
        end
        win_x[0] = win_x[1];
        win_x[1] = win_x[2];
        win_x[2] = x;
        win_y[0] = win_y[1];
        win_y[1] = win_y[2];
        win_y[2] = y;
        if (win_fill < 3)
            win_fill++;
    endfunction

    function automatic void check_sample();
        sample_t want;
        if (due_samples.size() == 0)
        begin
            $display("%0t: sample with none due, got x %0d y %0d end %0b",
                     $time, point_x, point_y, segment_end);
            sample_errors++;
            return;
        end
        want = due_samples.pop_front();
        if (point_x !== want.x)
        begin
            $display("%0t: point_x expected %0d got %0d", $time, want.x, point_x);
            sample_errors++;
        end
        if (point_y !== want.y)
        begin
            $display("%0t: point_y expected %0d got %0d", $time, want.y, point_y);
            sample_errors++;
        end
        if (segment_end !== want.last)
        begin
            $display("%0t: segment_end expected %0b got %0b", $time, want.last, segment_end);
            sample_errors++;
        end
    endfunction

    // driver: a transaction is taken when in_valid is high and in_stall low
    int      src_gap = 0;
    anchor_t next_anchor;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                tessellate_anchor(anchor_x, anchor_y, start_loop);
            // a stalled payload holds; otherwise present the next point or idle
            if (!in_valid || !in_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (anchor_feed.size() > 0)
                begin
                    next_anchor = anchor_feed.pop_front();
                    anchor_x   <= next_anchor.x;
                    anchor_y   <= next_anchor.y;
                    start_loop <= next_anchor.start;
                    in_valid   <= 1'b1;
                    if ($urandom_range(0, 99) < idle_pct)
                        src_gap = $urandom_range(1, 9);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each sample transaction and stalls the output in bursts
    int sink_hold = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_sample();
            if (sink_hold > 0)
            begin
                sink_hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 99) < idle_pct)
                    sink_hold = $urandom_range(1, 9);
            end
        end
    end

    function automatic void queue_anchor(coord_t x, coord_t y, logic start);
        anchor_t a;
        a.x     = x;
        a.y     = y;
        a.start = start;
        anchor_feed.insert(anchor_feed.size(), a);
    endfunction

    function automatic coord_t random_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? coord_t'(32767) : coord_t'(-32768);
            1, 2, 3: return coord_t'($urandom);
            default: return coord_t'($urandom_range(0, 2047)) - coord_t'(1024);
        endcase
    endfunction

    // well-formed closed loops and open paths, with stray restarts and lone points as noise
    function automatic void build_random_points(int count);
        coord_t lx[6];
        coord_t ly[6];
        int     k;
        int     made;
        made = 0;
        while (made < count)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    queue_anchor(random_coord(), random_coord(), 1'($urandom_range(0, 1)));
                    made++;
                end
                1, 2, 3, 4:
                begin
                    // closed loop of k anchors fed as k-1, 0..k-1, 0, 1
                    k = $urandom_range(3, 6);
                    for (int i = 0; i < k; i++)
                    begin
                        lx[i] = random_coord();
                        ly[i] = random_coord();
                    end
                    queue_anchor(lx[k-1], ly[k-1], 1'b1);
                    for (int i = 0; i < k; i++)
                        queue_anchor(lx[i], ly[i], 1'b0);
                    queue_anchor(lx[0], ly[0], 1'b0);
                    queue_anchor(lx[1], ly[1], 1'b0);
                    made += k + 3;
                end
                default:
                begin
                    k = $urandom_range(4, 12);
                    // most open paths restart the window, some continue the previous one
                    queue_anchor(random_coord(), random_coord(), $urandom_range(0, 4) != 0);
                    for (int i = 1; i < k; i++)
                        queue_anchor(random_coord(), random_coord(),
                                     $urandom_range(0, 99) < 8);
                    made += k;
                end
            endcase
        end
    endfunction

    task automatic write_seg_samples(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        seg_samples  = value;
    endtask

    // wait until every point is taken and every sample has arrived, then let the block settle
    task automatic wait_drained();
        do
            @(posedge clk);
        while (anchor_feed.size() != 0 || in_valid || due_samples.size() != 0);
        repeat (30) @(posedge clk);
    endtask

    int          phase_cfg[8];
    int          phase_idle[8] = '{40, 0, 30, 60, 20, 50, 30, 0};

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_x[i] = '0;
            win_y[i] = '0;
        end
        win_fill    = 0;
        seg_samples = CFG_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed points at the reset sample count
        idle_pct = 30;
        queue_anchor(16'sd0, 16'sd0, 1'b1);
        queue_anchor(16'sd0, 16'sd0, 1'b0);
        queue_anchor(16'sd0, 16'sd0, 1'b0);
        queue_anchor(16'sd0, 16'sd0, 1'b0);
        // alternating extremes overshoot and saturate both ways
        queue_anchor(-16'sd32768, 16'sd32767, 1'b1);
        queue_anchor(16'sd32767, -16'sd32768, 1'b0);
        queue_anchor(-16'sd32768, 16'sd32767, 1'b0);
        queue_anchor(16'sd32767, -16'sd32768, 1'b0);
        queue_anchor(-16'sd32768, -16'sd32768, 1'b0);
        // restart on a full window gives no samples
        queue_anchor(16'sd0, 16'sd0, 1'b1);
        // restart with only two points held
        queue_anchor(16'sd16, 16'sd16, 1'b1);
        queue_anchor(16'sd32, -16'sd32, 1'b0);
        queue_anchor(16'sd100, 16'sd100, 1'b1);
        queue_anchor(16'sd200, -16'sd200, 1'b0);
        queue_anchor(16'sd300, 16'sd300, 1'b0);
        queue_anchor(-16'sd400, -16'sd400, 1'b0);
        // checkerboard bit patterns
        queue_anchor(coord_t'(16'h5555), coord_t'(16'haaaa), 1'b0);
        queue_anchor(coord_t'(16'haaaa), coord_t'(16'h5555), 1'b0);
        wait_drained();

        // extremes of the sample count first, zero acting as one and 127 as 64
        phase_cfg = '{1, 64, 0, 127, 2, 0, 0, 0};
        for (int p = 5; p < 8; p++)
            phase_cfg[p] = $urandom_range(1, 16);
        for (int p = 0; p < 8; p++)
        begin
            write_seg_samples(CFG_W'(phase_cfg[p]));
            idle_pct = phase_idle[p];
            build_random_points(48);
            wait_drained();
        end
        repeat (10) @(posedge clk);

        if (sample_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
design/crt_pkg.sv
design/crt_dp.sv
design/crt_ctrl.sv
design/catmull_rom_curve_tessellator.sv
bench/tb.sv
